// ===== hw/rtl/mpq_pkg.sv =====
// Shared types, codes and sizes for the min-priority ready queue.
`default_nettype none

package mpq_pkg;

  // Default number of queue slots
  localparam int unsigned QUEUE_DEPTH_DEF = 16;

  // Opcodes
  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // Input item
  typedef struct packed {
    logic       opcode;
    logic [7:0] entry_id;
    logic [7:0] entry_prio;
  } in_t;

  // Result item
  typedef struct packed {
    logic [1:0] status;
    logic [7:0] out_id;
    logic [7:0] out_prio;
    logic [4:0] count;
    logic       is_empty;
  } out_t;

  // One stored slot
  typedef struct packed {
    logic [7:0] prio;
    logic [7:0] id;
  } entry_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load_imm;     // finish an enqueue or an empty dequeue right away
    logic start_scan;   // reset scan pointer
    logic step_scan;    // read one slot, compare previous one
    logic start_shift;  // point just past the chosen slot
    logic step_shift;   // read one slot, write previous one down
    logic finish;       // drop count, post dequeue result
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic queue_empty;
    logic scan_done;
    logic shift_done;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/min_priority_ready_queue.sv =====
// Top level of the min-priority ready queue: controller plus datapath.
//
// Usage: an input transfer carries an opcode (enqueue or dequeue), a process
// id and a priority. Each input transfer yields exactly one output transfer
// with a status, the removed id and priority (zero unless a dequeue succeeds),
// the entry count after the operation and an empty flag.
// Latency: an enqueue, or a dequeue on an empty queue, shows its result in the
// cycle after the input transfer. A dequeue with N entries held scans them one
// slot per cycle through the single read port of the slot memory, then closes
// the gap one slot per cycle, and only then posts its result to the output.
// Throughput: one item at a time; in_stall is high while an item is in work
// or while a finished result is held stalled by the receiver.
// Reset: rst (synchronous) empties the queue and drops any pending result;
// slot contents are not cleared since only slots below the count are read.
// Receiver stall: the result stays in the output register unchanged until
// out_stall drops; a dequeue in progress waits before posting its result.
`default_nettype none

module min_priority_ready_queue #(
  parameter int unsigned QUEUE_DEPTH = mpq_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire mpq_pkg::in_t in_data,
  output logic              out_valid,
  input  wire logic         out_stall,
  output mpq_pkg::out_t     out_data
);

  mpq_pkg::cmd_t cmd;
  mpq_pkg::sts_t sts;

  mpq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_opcode (in_data.opcode),
    .in_stall  (in_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  mpq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/mpq_datapath.sv =====
// Datapath: slot memory, count, scan/shift pointers, minimum tracker, result register.
`default_nettype none

module mpq_datapath #(
  parameter int unsigned QUEUE_DEPTH = mpq_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire mpq_pkg::in_t  in_data,
  input  wire mpq_pkg::cmd_t cmd,
  output mpq_pkg::sts_t      sts,
  output logic               out_valid,
  input  wire logic          out_stall,
  output mpq_pkg::out_t      out_data
);

  localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

  mpq_pkg::entry_t mem [QUEUE_DEPTH];

  logic [CW-1:0]   count;
  logic [CW-1:0]   count_next;
  logic [CW-1:0]   ptr;
  logic [AW-1:0]   rd_idx;
  logic            rd_vld;
  mpq_pkg::entry_t rd_q;
  mpq_pkg::entry_t best;
  logic [AW-1:0]   best_idx;

  logic            rd_en;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  mpq_pkg::entry_t wr_data;
  logic            more;
  logic            take_min;
  mpq_pkg::out_t   res;
  logic            res_load;

  assign more     = (ptr < count);
  assign rd_en    = (cmd.step_scan || cmd.step_shift) && more;
  assign take_min = rd_vld && ((rd_idx == '0) || (rd_q.prio < best.prio));

  // Status back to the controller
  assign sts.queue_empty = (count == '0);
  assign sts.scan_done   = !more && !rd_vld;
  assign sts.shift_done  = !more && !rd_vld;
  assign sts.out_free    = !out_valid || !out_stall;

  // Memory write select: enqueue at the tail or shift one slot down
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = count[AW-1:0];
    wr_data = '{prio: in_data.entry_prio, id: in_data.entry_id};
    if (cmd.load_imm && in_data.opcode == mpq_pkg::OP_ENQ && count != DEPTH_C) begin
      wr_en = 1'b1;
    end else if (cmd.step_shift && rd_vld) begin
      wr_en   = 1'b1;
      wr_addr = rd_idx - AW'(1);
      wr_data = rd_q;
    end
  end

  // Result and next count
  always_comb begin
    res        = '0;
    res_load   = 1'b0;
    count_next = count;
    if (cmd.load_imm) begin
      res_load = 1'b1;
      if (in_data.opcode == mpq_pkg::OP_ENQ) begin
        if (count == DEPTH_C) begin
          res.status = mpq_pkg::ST_FULL;
        end else begin
          count_next = count + CW'(1);
        end
      end else begin
        res.status = mpq_pkg::ST_EMPTY;
      end
    end else if (cmd.finish) begin
      res_load     = 1'b1;
      count_next   = count - CW'(1);
      res.out_id   = best.id;
      res.out_prio = best.prio;
    end
    res.count    = 5'(count_next);
    res.is_empty = (count_next == '0);
  end

  // Slot memory with registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[ptr[AW-1:0]];
    end
  end

  // Pointers, minimum tracker, count and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rd_vld    <= 1'b0;
      out_valid <= 1'b0;
      ptr       <= '0;
    end else begin
      count <= count_next;
      if (cmd.start_scan) begin
        ptr    <= '0;
        rd_vld <= 1'b0;
      end else if (cmd.start_shift) begin
        ptr    <= CW'(best_idx) + CW'(1);
        rd_vld <= 1'b0;
      end else if (cmd.step_scan || cmd.step_shift) begin
        rd_vld <= more;
        if (more) begin
          ptr    <= ptr + CW'(1);
          rd_idx <= ptr[AW-1:0];
        end
      end
      // strict compare keeps the earliest arrival on a tie
      if (cmd.step_scan && take_min) begin
        best     <= rd_q;
        best_idx <= rd_idx;
      end
      if (res_load) begin
        out_valid <= 1'b1;
        out_data  <= res;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/mpq_ctrl.sv =====
// Controller: sequences enqueue, dequeue scan, gap close and result posting.
`default_nettype none

module mpq_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  input  wire logic          in_opcode,
  output logic               in_stall,
  input  wire mpq_pkg::sts_t sts,
  output mpq_pkg::cmd_t      cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_FINISH
  } state_t;

  state_t state;
  state_t state_next;
  logic   take;

  // New item only when idle and the result register can take a result
  assign in_stall = !((state == S_IDLE) && sts.out_free);
  assign take     = in_valid && !in_stall;

  // Command decode
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (take) begin
          if (in_opcode == mpq_pkg::OP_ENQ || sts.queue_empty) begin
            cmd.load_imm = 1'b1;
          end else begin
            cmd.start_scan = 1'b1;
            state_next     = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (sts.scan_done) begin
          cmd.start_shift = 1'b1;
          state_next      = S_SHIFT;
        end else begin
          cmd.step_scan = 1'b1;
        end
      end
      S_SHIFT: begin
        if (sts.shift_done) begin
          state_next = S_FINISH;
        end else begin
          cmd.step_shift = 1'b1;
        end
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the min-priority ready queue: directed and random traffic.
module tb_top;
  import mpq_pkg::*;

  localparam int unsigned DEPTH = QUEUE_DEPTH_DEF;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES = 2 * DEPTH + 8;
  localparam int unsigned PHASE_ITEMS = 150;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  min_priority_ready_queue #(.QUEUE_DEPTH(DEPTH)) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  always #5 clk = ~clk;

  // Commands waiting to be sent and results waiting to arrive
  in_t sched_ops[$];
  out_t pending_results[$];

  // Shadow copy of the ready queue
  entry_t ready_slots[DEPTH];
  int unsigned ready_count = 0;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned mismatches = 0;
  int unsigned n_enq = 0, n_deq = 0, n_full = 0, n_empty = 0, n_results = 0;
  int unsigned quiet_cycles = 0;

  task automatic flag_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic cmp_field(input string name, input int unsigned got, input int unsigned want);
    if (got != want)
      flag_mismatch($sformatf("result %0d %s got %0d want %0d", n_results, name, got, want));
  endtask

  // Work out the result of one accepted command and update the shadow queue
  task automatic apply_sched_op(input in_t op);
    out_t res;
    int unsigned best;
    res = '0;
    res.status = ST_OK;
    if (op.opcode == OP_ENQ) begin
      n_enq++;
      if (ready_count >= DEPTH) begin
        res.status = ST_FULL;
        n_full++;
      end else begin
        ready_slots[ready_count].id = op.entry_id;
        ready_slots[ready_count].prio = op.entry_prio;
        ready_count++;
      end
    end else begin
      n_deq++;
      if (ready_count == 0) begin
        res.status = ST_EMPTY;
        n_empty++;
      end else begin
        // strict less-than keeps the earliest arrival on a tie
        best = 0;
        for (int unsigned i = 1; i < ready_count; i++)
          if (ready_slots[i].prio < ready_slots[best].prio) best = i;
        res.out_id = ready_slots[best].id;
        res.out_prio = ready_slots[best].prio;
        for (int unsigned i = best; i + 1 < ready_count; i++)
          ready_slots[i] = ready_slots[i + 1];
        ready_count--;
      end
    end
    res.count = ready_count[4:0];
    res.is_empty = (ready_count == 0);
    pending_results.push_back(res);
  endtask

  // Driver: present queued commands, idling at random
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        apply_sched_op(in_data);
        void'(sched_ops.pop_front());
      end
      if (in_valid && in_stall) begin
        // hold the stalled transfer as it is
      end else if (sched_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data <= sched_ops[0];
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: check each accepted result against the oldest expectation
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        n_results++;
        if (pending_results.size() == 0) begin
          flag_mismatch("result arrived with nothing expected");
        end else begin
          out_t want;
          want = pending_results.pop_front();
          cmp_field("status", out_data.status, want.status);
          cmp_field("out_id", out_data.out_id, want.out_id);
          cmp_field("out_prio", out_data.out_prio, want.out_prio);
          cmp_field("count", out_data.count, want.count);
          cmp_field("is_empty", out_data.is_empty, want.is_empty);
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
      $display("** min_priority_ready_queue: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_op(input logic opc, input logic [7:0] id, input logic [7:0] prio);
    in_t op;
    op.opcode = opc;
    op.entry_id = id;
    op.entry_prio = prio;
    sched_ops.push_back(op);
  endtask

  // Runs of mostly enqueues or mostly dequeues so the queue swings
  // between empty and full; narrow priorities make ties common
  task automatic push_random_ops(input int unsigned total);
    int unsigned left;
    int unsigned run;
    logic fill;
    logic opc;
    logic [7:0] prio;
    left = total;
    while (left > 0) begin
      fill = 1'($urandom_range(1));
      run = $urandom_range(1, 20);
      if (run > left) run = left;
      for (int unsigned k = 0; k < run; k++) begin
        opc = ($urandom_range(99) < 85) ? (fill ? OP_ENQ : OP_DEQ) : (fill ? OP_DEQ : OP_ENQ);
        prio = $urandom_range(1) ? 8'($urandom_range(3)) : 8'($urandom_range(255));
        push_op(opc, 8'($urandom_range(255)), prio);
      end
      left -= run;
    end
  endtask

  task automatic wait_idle();
    while (sched_ops.size() != 0 || pending_results.size() != 0) @(negedge clk);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: dequeue on empty, fill with extremes and ties, overfill, partial drain
    push_op(OP_DEQ, 8'hFF, 8'hFF);
    push_op(OP_ENQ, 8'h00, 8'h80);
    push_op(OP_ENQ, 8'hFF, 8'hFF);
    push_op(OP_ENQ, 8'h55, 8'h00);
    push_op(OP_ENQ, 8'hAA, 8'h00);
    for (int unsigned i = 0; i < DEPTH - 4; i++)
      push_op(OP_ENQ, 8'(8'h10 + i), 8'(i % 3));
    push_op(OP_ENQ, 8'hA5, 8'h00);
    repeat (5) push_op(OP_DEQ, 8'h00, 8'h00);

    // Random traffic under each idling pattern
    for (int ph = 0; ph < 4; ph++) begin
      wait_idle();
      case (ph)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 49; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 49; end
        default: begin send_idle_pct = 34; recv_stall_pct = 34; end
      endcase
      push_random_ops(PHASE_ITEMS);
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (pending_results.size() != 0) flag_mismatch("expected results left over");

    $display("covered %0d enqueues (%0d dropped full), %0d dequeues (%0d on empty)",
             n_enq, n_full, n_deq, n_empty);
    $display("checked %0d results under four idle/stall patterns, %0d mismatches",
             n_results, mismatches);
    if (mismatches == 0) begin
      $display("** min_priority_ready_queue: PASSED **");
    end else begin
      $display("** min_priority_ready_queue: FAILED **");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/mpq_pkg.sv
hw/rtl/mpq_datapath.sv
hw/rtl/mpq_ctrl.sv
hw/rtl/min_priority_ready_queue.sv
tb/tb_top.sv
